@@ rtl/core/mhom_pkg.sv @@
`default_nettype none
package mhom_pkg;

  typedef enum logic [3:0] {
    M_NAME       = 4'd0,
    M_LINE_START = 4'd1,
    M_BODY       = 4'd2,
    M_SEEN_F     = 4'd3,
    M_SEEN_R     = 4'd4,
    M_SEEN_O     = 4'd5,
    M_SEEN_M     = 4'd6,
    M_VALUE      = 4'd7,
    M_HDR_LINE   = 4'd8
  } mode_t;

  typedef enum logic [2:0] {
    K_PLAIN  = 3'd0,
    K_UNDER  = 3'd1,
    K_BOLD   = 3'd2,
    K_REPLAY = 3'd3,
    K_MARK   = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic [2:0] cnt;
  } cmd_t;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_M     = 8'h6D;

  // Index of the final output byte of a command.
  function automatic logic [3:0] cmd_last_idx(input cmd_t c);
    logic [3:0] r;
    case (c.kind)
      K_PLAIN:  r = 4'd0;
      K_UNDER:  r = 4'd2;
      K_BOLD:   r = 4'd2;
      K_REPLAY: r = {1'b0, c.cnt};
      K_MARK:   r = 4'd12;
      default:  r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] from_word(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = CH_F;
      2'd1:    r = CH_R;
      2'd2:    r = CH_O;
      default: r = CH_M;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] from_mark(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0, 4'd3, 4'd6, 4'd9:  r = CH_UNDER;
      4'd1, 4'd4, 4'd7, 4'd10: r = CH_BS;
      4'd2:                    r = CH_F;
      4'd5:                    r = CH_R;
      4'd8:                    r = CH_O;
      4'd11:                   r = CH_M;
      default:                 r = CH_SPACE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cmd_byte(input cmd_t c, input logic [3:0] idx);
    logic [7:0] r;
    case (c.kind)
      K_PLAIN:  r = c.ch;
      K_UNDER:  r = (idx == 4'd0) ? CH_UNDER : ((idx == 4'd1) ? CH_BS : c.ch);
      K_BOLD:   r = (idx == 4'd1) ? CH_BS : c.ch;
      K_REPLAY: r = (idx == {1'b0, c.cnt}) ? c.ch : from_word(idx[1:0]);
      K_MARK:   r = from_mark(idx);
      default:  r = c.ch;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/mhom_front.sv @@
`default_nettype none
module mhom_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte,
  input  wire logic          q_full,
  output logic               q_push,
  output mhom_pkg::cmd_t     q_cmd
);

  mhom_pkg::mode_t mode_r, mode_nxt;
  logic            blank_r, blank_nxt;
  logic            accept;
  logic            has_cmd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && has_cmd;

  // Next mode and blank flag.
  always_comb begin
    mode_nxt  = mode_r;
    blank_nxt = blank_r;
    unique case (mode_r)
      mhom_pkg::M_BODY: begin
        if (in_byte == mhom_pkg::CH_NL) mode_nxt = mhom_pkg::M_LINE_START;
      end
      mhom_pkg::M_SEEN_F: begin
        mode_nxt = (in_byte == mhom_pkg::CH_R) ? mhom_pkg::M_SEEN_R : mhom_pkg::M_BODY;
      end
      mhom_pkg::M_SEEN_R: begin
        mode_nxt = (in_byte == mhom_pkg::CH_O) ? mhom_pkg::M_SEEN_O : mhom_pkg::M_BODY;
      end
      mhom_pkg::M_SEEN_O: begin
        mode_nxt = (in_byte == mhom_pkg::CH_M) ? mhom_pkg::M_SEEN_M : mhom_pkg::M_BODY;
      end
      mhom_pkg::M_SEEN_M: begin
        mode_nxt = (in_byte == mhom_pkg::CH_SPACE) ? mhom_pkg::M_VALUE : mhom_pkg::M_BODY;
      end
      mhom_pkg::M_HDR_LINE: begin
        blank_nxt = 1'b0;
        if (in_byte == mhom_pkg::CH_SPACE || in_byte == mhom_pkg::CH_TAB) begin
          mode_nxt = mhom_pkg::M_VALUE;
        end else if (in_byte == mhom_pkg::CH_NL) begin
          mode_nxt = mhom_pkg::M_BODY;
        end else if (in_byte == mhom_pkg::CH_COLON) begin
          mode_nxt = mhom_pkg::M_VALUE;
        end else begin
          mode_nxt = mhom_pkg::M_NAME;
        end
      end
      mhom_pkg::M_NAME: begin
        if (in_byte == mhom_pkg::CH_NL) begin
          mode_nxt = mhom_pkg::M_HDR_LINE;
        end else if (in_byte == mhom_pkg::CH_SPACE) begin
          blank_nxt = 1'b1;
        end else if (in_byte == mhom_pkg::CH_COLON && !blank_r) begin
          mode_nxt = mhom_pkg::M_VALUE;
        end
      end
      mhom_pkg::M_VALUE: begin
        if (in_byte == mhom_pkg::CH_NL) mode_nxt = mhom_pkg::M_HDR_LINE;
      end
      default: begin
        // Line start, and any code that cannot arise.
        if (in_byte == mhom_pkg::CH_F) begin
          mode_nxt = mhom_pkg::M_SEEN_F;
        end else if (in_byte == mhom_pkg::CH_NL) begin
          mode_nxt = mhom_pkg::M_LINE_START;
        end else begin
          mode_nxt = mhom_pkg::M_BODY;
        end
      end
    endcase
  end

  // Command for the back end; a held match prefix produces none.
  always_comb begin
    has_cmd     = 1'b1;
    q_cmd.kind  = mhom_pkg::K_PLAIN;
    q_cmd.ch    = in_byte;
    q_cmd.cnt   = 3'd0;
    unique case (mode_r)
      mhom_pkg::M_BODY: begin
        q_cmd.kind = mhom_pkg::K_PLAIN;
      end
      mhom_pkg::M_SEEN_F: begin
        has_cmd    = (in_byte != mhom_pkg::CH_R);
        q_cmd.kind = mhom_pkg::K_REPLAY;
        q_cmd.cnt  = 3'd1;
      end
      mhom_pkg::M_SEEN_R: begin
        has_cmd    = (in_byte != mhom_pkg::CH_O);
        q_cmd.kind = mhom_pkg::K_REPLAY;
        q_cmd.cnt  = 3'd2;
      end
      mhom_pkg::M_SEEN_O: begin
        has_cmd    = (in_byte != mhom_pkg::CH_M);
        q_cmd.kind = mhom_pkg::K_REPLAY;
        q_cmd.cnt  = 3'd3;
      end
      mhom_pkg::M_SEEN_M: begin
        q_cmd.kind = (in_byte == mhom_pkg::CH_SPACE) ? mhom_pkg::K_MARK : mhom_pkg::K_REPLAY;
        q_cmd.cnt  = 3'd4;
      end
      mhom_pkg::M_HDR_LINE, mhom_pkg::M_NAME: begin
        if (in_byte == mhom_pkg::CH_NL || in_byte == mhom_pkg::CH_SPACE ||
            (in_byte == mhom_pkg::CH_TAB && mode_r == mhom_pkg::M_HDR_LINE)) begin
          // A blank only starts a continuation at the head of a header line.
          q_cmd.kind = (in_byte == mhom_pkg::CH_SPACE && mode_r == mhom_pkg::M_NAME) ?
                       mhom_pkg::K_UNDER : mhom_pkg::K_PLAIN;
        end else begin
          q_cmd.kind = mhom_pkg::K_UNDER;
        end
      end
      mhom_pkg::M_VALUE: begin
        q_cmd.kind = (in_byte == mhom_pkg::CH_NL) ? mhom_pkg::K_PLAIN : mhom_pkg::K_BOLD;
      end
      default: begin
        has_cmd    = (in_byte != mhom_pkg::CH_F);
        q_cmd.kind = mhom_pkg::K_PLAIN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= mhom_pkg::M_LINE_START;
      blank_r <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      blank_r <= blank_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/mhom_cmd_fifo.sv @@
`default_nettype none
module mhom_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire mhom_pkg::cmd_t  push_cmd,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output mhom_pkg::cmd_t       head_cmd
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  mhom_pkg::cmd_t  slot_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);
  assign head_cmd = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/mhom_back.sv @@
`default_nettype none
module mhom_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_empty,
  input  wire mhom_pkg::cmd_t  q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last
);

  mhom_pkg::cmd_t cur_r;
  logic           cur_valid_r, cur_valid_nxt;
  logic [3:0]     idx_r, idx_nxt;
  logic           out_valid_r;
  logic [7:0]     out_byte_r;
  logic           out_last_r;
  logic           advance;
  logic           cur_done;

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // A byte of the current command moves into the output register whenever that register is free or drains.
  assign advance  = cur_valid_r && (!out_valid_r || out_ready);
  assign cur_done = advance && (idx_r == mhom_pkg::cmd_last_idx(cur_r));
  assign q_pop    = !q_empty && (!cur_valid_r || cur_done);

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      idx_nxt       = 4'd0;
    end else if (cur_done) begin
      cur_valid_nxt = 1'b0;
      idx_nxt       = 4'd0;
    end else if (advance) begin
      idx_nxt = idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_head;
    if (advance) begin
      out_byte_r <= mhom_pkg::cmd_byte(cur_r, idx_r);
      out_last_r <= (idx_r == mhom_pkg::cmd_last_idx(cur_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      if (advance)        out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/mail_header_overstrike_marker.sv @@
`default_nettype none
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_byte[7:0]
// out      output     out_valid / out_ready  out_byte[7:0], out_last
//
// Each input byte is classified combinationally and queued as a command; the back end
// then emits one output byte per cycle while out_ready is high: 1 for body text, a
// header newline or a leading blank, 3 for other header bytes, 2 to 5 for a failed
// "From" match, 13 for the "From " marker and none while a match is held. The output
// rate sets the throughput; input stalls only when the command queue is full. Reset
// is synchronous and returns the block to line start.
module mail_header_overstrike_marker #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  mhom_pkg::cmd_t push_cmd, head_cmd;
  logic           q_push, q_full, q_pop, q_empty;

  mhom_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  mhom_cmd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_cmd (head_cmd)
  );

  mhom_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mhom_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TEXT_LENGTH = 130;
  localparam int DRAIN_CYCLES = 50;
  localparam int MAX_PRINTED = 50;

  // Keeps its own copy of the marker state and the bytes still owed on the
  // output side. Each entry holds the last flag above the byte.
  class markup_scoreboard;
    mode_t mode = M_LINE_START;
    bit blank_in_name = 1'b0;
    logic [7:0] burst[$];
    logic [8:0] expected_chars[$];
    int checked = 0;
    int mismatches = 0;
    logic [7:0] from_chars[4] = '{CH_F, CH_R, CH_O, CH_M};
    logic [7:0] mark_chars[13] = '{CH_UNDER, CH_BS, CH_F, CH_UNDER, CH_BS, CH_R,
                                   CH_UNDER, CH_BS, CH_O, CH_UNDER, CH_BS, CH_M,
                                   CH_SPACE};

    function bit idle();
      return expected_chars.size() == 0;
    endfunction

    // A broken "From" match gives back the letters held so far, then the byte.
    function void flush_prefix(int held, logic [7:0] c);
      for (int i = 0; i < held; i++) burst.push_back(from_chars[i]);
      burst.push_back(c);
      mode = M_BODY;
    endfunction

    function void underline_name(logic [7:0] c);
      if (c == CH_NL) begin
        burst.push_back(c);
        mode = M_HDR_LINE;
      end else begin
        burst.push_back(CH_UNDER);
        burst.push_back(CH_BS);
        burst.push_back(c);
        if (c == CH_SPACE) blank_in_name = 1'b1;
        if (c == CH_COLON && !blank_in_name) mode = M_VALUE;
      end
    endfunction

    function void accept_byte(logic [7:0] c);
      burst.delete();
      case (mode)
        M_BODY: begin
          if (c == CH_NL) mode = M_LINE_START;
          burst.push_back(c);
        end
        M_SEEN_F: begin
          if (c == CH_R) mode = M_SEEN_R;
          else flush_prefix(1, c);
        end
        M_SEEN_R: begin
          if (c == CH_O) mode = M_SEEN_O;
          else flush_prefix(2, c);
        end
        M_SEEN_O: begin
          if (c == CH_M) mode = M_SEEN_M;
          else flush_prefix(3, c);
        end
        M_SEEN_M: begin
          if (c == CH_SPACE) begin
            foreach (mark_chars[i]) burst.push_back(mark_chars[i]);
            mode = M_VALUE;
          end else begin
            flush_prefix(4, c);
          end
        end
        M_HDR_LINE: begin
          blank_in_name = 1'b0;
          if (c == CH_SPACE || c == CH_TAB) begin
            mode = M_VALUE;
            burst.push_back(c);
          end else if (c == CH_NL) begin
            mode = M_BODY;
            burst.push_back(c);
          end else begin
            mode = M_NAME;
            underline_name(c);
          end
        end
        M_NAME: underline_name(c);
        M_VALUE: begin
          burst.push_back(c);
          if (c == CH_NL) begin
            mode = M_HDR_LINE;
          end else begin
            burst.push_back(CH_BS);
            burst.push_back(c);
          end
        end
        default: begin
          if (c == CH_F) begin
            mode = M_SEEN_F;
          end else begin
            mode = (c == CH_NL) ? M_LINE_START : M_BODY;
            burst.push_back(c);
          end
        end
      endcase
      foreach (burst[i]) expected_chars.push_back({i == burst.size() - 1, burst[i]});
    endfunction

    task report(string msg);
      if (mismatches < MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_out(logic [7:0] b, logic l);
      logic [8:0] want;
      checked++;
      if (expected_chars.size() == 0) begin
        report($sformatf("output byte 0x%02h with nothing outstanding", b));
        return;
      end
      want = expected_chars.pop_front();
      if (b !== want[7:0])
        report($sformatf("out_byte 0x%02h, wanted 0x%02h", b, want[7:0]));
      if (l !== want[8])
        report($sformatf("out_last %b on byte 0x%02h, wanted %b", l, b, want[8]));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  markup_scoreboard sb = new;
  logic [7:0] mail_text[$];
  int cycles = 0;

  always #5 clk = ~clk;

  mail_header_overstrike_marker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  // Inputs are noted before outputs are checked, so a same-edge result still finds
  // its expectation waiting.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.accept_byte(in_byte);
      if (out_valid && out_ready) sb.check_out(out_byte, out_last);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) mail_text.push_back(s[i]);
  endtask

  // Free text without a newline; wide text also draws from the whole byte range.
  task automatic add_text(int n, bit wide);
    logic [7:0] c;
    repeat (n) begin
      if (wide && $urandom_range(0, 3) == 0) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(8'h20, 8'h7e));
      if (c == CH_NL) c = CH_TAB;
      mail_text.push_back(c);
    end
  endtask

  // A body line that opens like "From" and then breaks off; always ends at line start.
  task automatic add_partial_line();
    string word;
    int k;
    logic [7:0] c;
    word = "From";
    k = $urandom_range(1, 4);
    for (int i = 0; i < k; i++) mail_text.push_back(word[i]);
    if ($urandom_range(0, 3) == 0) begin
      mail_text.push_back(CH_NL);
      mail_text.push_back(CH_NL);
    end else begin
      c = 8'($urandom_range(8'h21, 8'h7e));
      if (k < 4 && c == word[k]) c = "#";
      mail_text.push_back(c);
      add_text($urandom_range(0, 3), 1'b1);
      mail_text.push_back(CH_NL);
    end
  endtask

  function automatic logic [7:0] name_letter();
    return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h41, 8'h5a))
                                       : 8'($urandom_range(8'h61, 8'h7a));
  endfunction

  task automatic send_byte(logic [7:0] b, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    int directed_count;
    int r;
    int gap;

    // Header with a full-scale value byte, a name with a blank before its colon,
    // a proper field with a zero value byte, a tab continuation, then the empty
    // line that closes the header, two empty body lines and a broken match.
    push_str("From ");
    mail_text.push_back(8'hff);
    mail_text.push_back(CH_NL);
    push_str("a b:");
    mail_text.push_back(CH_NL);
    push_str("K:");
    mail_text.push_back(8'h00);
    mail_text.push_back(CH_NL);
    mail_text.push_back(CH_TAB);
    mail_text.push_back(CH_NL);
    mail_text.push_back(CH_NL);
    mail_text.push_back(CH_NL);
    mail_text.push_back(CH_NL);
    push_str("Fr!");
    mail_text.push_back(CH_NL);
    directed_count = mail_text.size();

    // Every chunk below leaves the marker at line start.
    while (mail_text.size() < TEXT_LENGTH - 3) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        push_str("From ");
        add_text($urandom_range(0, 3), 1'b1);
        mail_text.push_back(CH_NL);
        repeat ($urandom_range(0, 3)) begin
          mail_text.push_back(name_letter());
          repeat ($urandom_range(0, 2))
            mail_text.push_back(($urandom_range(0, 4) == 0) ? CH_SPACE : name_letter());
          if ($urandom_range(0, 9) != 0) mail_text.push_back(CH_COLON);
          add_text($urandom_range(0, 4), 1'b1);
          mail_text.push_back(CH_NL);
          if ($urandom_range(0, 2) == 0) begin
            mail_text.push_back(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB);
            add_text($urandom_range(0, 3), 1'b1);
            mail_text.push_back(CH_NL);
          end
        end
        mail_text.push_back(CH_NL);
        add_text($urandom_range(0, 4), 1'b1);
        mail_text.push_back(CH_NL);
        repeat ($urandom_range(0, 2)) add_partial_line();
      end else if (r < 8) begin
        repeat ($urandom_range(1, 3)) add_partial_line();
      end else begin
        repeat ($urandom_range(1, 6)) mail_text.push_back(8'($urandom_range(0, 255)));
        repeat (3) mail_text.push_back(CH_NL);
      end
    end
    // A match still held when the text runs out is never emitted.
    push_str("Fro");

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (mail_text[idx]) begin
      if (idx == directed_count) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (!sb.idle()) @(negedge clk);
      end
      r = $urandom_range(0, 99);
      if ((idx % 40) < 10 || r < 60) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      send_byte(mail_text[idx], gap);
    end
    in_valid <= 1'b0;

    while (!sb.idle()) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Receiver: random stalls outside calm windows, plus one long hold-off while the
  // sender keeps offering, so the command queue fills and the input stalls.
  initial begin
    int stall_left;
    bit long_done;
    int rx_cycle;
    stall_left = 0;
    long_done = 1'b0;
    rx_cycle = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!long_done && sb.checked >= 80) begin
          stall_left = 300;
          long_done = 1'b1;
        end else if ((rx_cycle % 200) >= 50 && $urandom_range(0, 9) < 3) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
        end
      end
    end
  end

endmodule

@@ files.f @@
rtl/core/mhom_pkg.sv
rtl/core/mhom_front.sv
rtl/core/mhom_cmd_fifo.sv
rtl/core/mhom_back.sv
rtl/core/mail_header_overstrike_marker.sv
dv/tb_top.sv
